// ===== rtl/fdr_pkg.sv =====
// Shared widths and constants for the Fresnel reflectance pipeline.
`default_nettype none
package fdr_pkg;
    localparam int unsigned IDX_W = 16;
    localparam int unsigned CMP_W = 16;
    localparam int unsigned OUT_W = 16;
    localparam int unsigned SQ_STEPS = 2;
    localparam int unsigned DIV_STEPS = 2;
    localparam logic [OUT_W-1:0] OUT_ONE = 16'd32768;
    localparam logic signed [29:0] Q28_ONE = 30'sd268435456;
endpackage
`default_nettype wire

// ===== rtl/fdr_div_stage.sv =====
// One pipeline stage of a restoring divider: two quotient bits per stage.
`default_nettype none
module fdr_div_stage (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_rem,
    input  wire logic [63:0] in_den,
    input  wire logic [63:0] in_quo,
    output logic             out_valid,
    output logic [63:0]      out_rem,
    output logic [63:0]      out_quo
);
    logic [63:0] rem_a;
    logic [63:0] quo_a;
    logic [63:0] rem_b;
    logic [63:0] quo_b;

    // two dependent compare-subtract steps
    always_comb
    begin
        rem_a = {in_rem[62:0], 1'b0};
        quo_a = {in_quo[62:0], 1'b0};
        if (rem_a >= in_den)
        begin
            rem_a = rem_a - in_den;
            quo_a[0] = 1'b1;
        end
        rem_b = {rem_a[62:0], 1'b0};
        quo_b = {quo_a[62:0], 1'b0};
        if (rem_b >= in_den)
        begin
            rem_b = rem_b - in_den;
            quo_b[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        out_rem <= rem_b;
        out_quo <= quo_b;
    end
endmodule
`default_nettype wire

// ===== rtl/fresnel_dielectric_reflectance_unit.sv =====
// Top level: fully pipelined unpolarized Fresnel reflectance of a dielectric boundary.
//
// channel  | signals                                   | handshake
// request  | start, busy, dir_*, normal_*, source_index| taken when start && !busy
// result   | done, reflect_fraction, total_internal    | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_data            | written when valid && ready
//
// One request may enter every cycle; busy is always low.
// The pipeline holds six front stages up to the TIR compare, the 15-stage sinT2
// divider, the radicand stage, the 15-stage square root, three product, magnitude
// and saturation stages, the 16-stage coefficient dividers, squares, output.
// Reset clears the valid bits and loads material_index with 1.5.
// The result side cannot stall, so nothing in the pipe ever waits.
`default_nettype none
module fresnel_dielectric_reflectance_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [15:0] dir_x,
    input  wire logic signed [15:0] dir_y,
    input  wire logic signed [15:0] dir_z,
    input  wire logic signed [15:0] normal_x,
    input  wire logic signed [15:0] normal_y,
    input  wire logic signed [15:0] normal_z,
    input  wire logic [15:0] source_index,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic [15:0]      reflect_fraction,
    output logic             total_internal
);
    localparam int unsigned DVN = 16;   // divider stages: 1 + 30 bits, two per stage

    logic [15:0] material_index_reg;
    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            material_index_reg <= 16'd24576;
        else if (cfg_valid)
            material_index_reg <= cfg_data;
    end

    // ---- stage 1: products of the dot product
    logic v1_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [15:0] n1_1_reg, n2_1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        px_reg <= dir_x * normal_x;
        py_reg <= dir_y * normal_y;
        pz_reg <= dir_z * normal_z;
        n1_1_reg <= source_index;
        n2_1_reg <= material_index_reg;
    end

    // ---- stage 2: cosI, saturated
    logic v2_reg;
    logic signed [29:0] ci_2_reg;
    logic [15:0] n1_2_reg, n2_2_reg;
    logic signed [34:0] ci_raw;
    always_comb
    begin
        ci_raw = -(35'(px_reg) + 35'(py_reg) + 35'(pz_reg));
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (ci_raw > 35'(fdr_pkg::Q28_ONE))
            ci_2_reg <= fdr_pkg::Q28_ONE;
        else if (ci_raw < -35'(fdr_pkg::Q28_ONE))
            ci_2_reg <= -fdr_pkg::Q28_ONE;
        else
            ci_2_reg <= ci_raw[29:0];
        n1_2_reg <= n1_1_reg;
        n2_2_reg <= n2_1_reg;
    end

    // ---- stage 3: cosI^2, n1^2, n2^2
    logic v3_reg;
    logic [56:0] cisq_3_reg;
    logic [31:0] n1sq_3_reg, n2sq_3_reg;
    logic signed [29:0] ci_3_reg;
    logic [15:0] n1_3_reg, n2_3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        cisq_3_reg <= 57'(60'(ci_2_reg) * 60'(ci_2_reg));
        n1sq_3_reg <= n1_2_reg * n1_2_reg;
        n2sq_3_reg <= n2_2_reg * n2_2_reg;
        ci_3_reg <= ci_2_reg;
        n1_3_reg <= n1_2_reg;
        n2_3_reg <= n2_2_reg;
    end

    // ---- stage 4: s28 = (1 - cosI^2) truncated
    logic v4_reg;
    logic [28:0] s28_4_reg;
    logic [31:0] n1sq_4_reg, n2sq_4_reg;
    logic signed [29:0] ci_4_reg;
    logic [15:0] n1_4_reg, n2_4_reg;
    logic [56:0] s56;
    assign s56 = (57'd1 << 56) - cisq_3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        s28_4_reg <= s56[56:28];
        n1sq_4_reg <= n1sq_3_reg;
        n2sq_4_reg <= n2sq_3_reg;
        ci_4_reg <= ci_3_reg;
        n1_4_reg <= n1_3_reg;
        n2_4_reg <= n2_3_reg;
    end

    // ---- stage 5: lhs = n1^2 * s28, one 32x29 product
    logic v5_reg;
    logic [60:0] lhs_5_reg;
    logic [31:0] n2sq_5_reg;
    logic signed [29:0] ci_5_reg;
    logic [15:0] n1_5_reg, n2_5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else        v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        lhs_5_reg <= n1sq_4_reg * s28_4_reg;
        n2sq_5_reg <= n2sq_4_reg;
        ci_5_reg <= ci_4_reg;
        n1_5_reg <= n1_4_reg;
        n2_5_reg <= n2_4_reg;
    end

    // ---- stage 6: TIR compare; set up sinT2 divide
    logic v6_reg;
    logic tir_6_reg;
    logic [60:0] lhs_6_reg;
    logic [31:0] n2sq_6_reg;
    logic signed [29:0] ci_6_reg;
    logic [15:0] n1_6_reg, n2_6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else        v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        tir_6_reg <= 61'(lhs_5_reg) > {n2sq_5_reg[31:0], 28'd0} >> 0
                     ? 1'b1 : 1'b0;
        lhs_6_reg <= lhs_5_reg;
        n2sq_6_reg <= n2sq_5_reg;
        ci_6_reg <= ci_5_reg;
        n1_6_reg <= n1_5_reg;
        n2_6_reg <= n2_5_reg;
    end

    // ---- sinT2 = lhs / n2sq, clamped to 2^28. Without TIR lhs <= n2sq<<28,
    // so the quotient is at most 2^28: 29 bits, radix-2 restoring over 15 stages.
    localparam int unsigned SDN = 15;
    logic        sv_reg   [SDN+1];
    logic [60:0] srem_reg [SDN+1];
    logic [28:0] squo_reg [SDN+1];
    logic [60:0] sden_reg [SDN+1];
    logic        stir_reg [SDN+1];
    logic signed [29:0] sci_reg [SDN+1];
    logic [15:0] sn1_reg [SDN+1];
    logic [15:0] sn2_reg [SDN+1];
    logic        sdz_reg [SDN+1];

    always_comb
    begin
        sv_reg[0] = v6_reg;
        srem_reg[0] = lhs_6_reg;
        squo_reg[0] = 29'd0;
        sden_reg[0] = 61'(n2sq_6_reg);
        stir_reg[0] = tir_6_reg;
        sci_reg[0] = ci_6_reg;
        sn1_reg[0] = n1_6_reg;
        sn2_reg[0] = n2_6_reg;
        sdz_reg[0] = (n2sq_6_reg == 32'd0);
    end

    // each stage resolves quotient bits 28-2k and 27-2k; the last stage resolves only bit 0
    for (genvar k = 0; k < SDN; k++)
    begin : g_sdiv
        logic [60:0] r_a, r_b;
        logic [28:0] q_a, q_b;
        localparam int unsigned BA = 28 - 2 * k;
        always_comb
        begin
            r_a = srem_reg[k];
            q_a = squo_reg[k];
            if ((sden_reg[k] << BA) <= r_a && sden_reg[k] != 61'd0
                && (sden_reg[k] >> (61 - BA)) == 61'd0)
            begin
                r_a = r_a - (sden_reg[k] << BA);
                q_a[BA] = 1'b1;
            end
            r_b = r_a;
            q_b = q_a;
            if (BA >= 1)
            begin
                if ((sden_reg[k] << (BA - 1)) <= r_b && sden_reg[k] != 61'd0
                    && (sden_reg[k] >> (62 - BA)) == 61'd0)
                begin
                    r_b = r_b - (sden_reg[k] << (BA - 1));
                    q_b[(BA >= 1) ? BA - 1 : 0] = 1'b1;
                end
            end
        end
        logic v_r;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_r <= 1'b0;
            else        v_r <= sv_reg[k];
        end
        logic [60:0] rem_r, den_r;
        logic [28:0] quo_r;
        logic tir_r, dz_r;
        logic signed [29:0] ci_r;
        logic [15:0] n1_r, n2_r;
        always_ff @(posedge clk)
        begin
            rem_r <= r_b;
            quo_r <= q_b;
            den_r <= sden_reg[k];
            tir_r <= stir_reg[k];
            dz_r <= sdz_reg[k];
            ci_r <= sci_reg[k];
            n1_r <= sn1_reg[k];
            n2_r <= sn2_reg[k];
        end
        always_comb
        begin
            sv_reg[k+1] = v_r;
            srem_reg[k+1] = rem_r;
            squo_reg[k+1] = quo_r;
            sden_reg[k+1] = den_r;
            stir_reg[k+1] = tir_r;
            sdz_reg[k+1] = dz_r;
            sci_reg[k+1] = ci_r;
            sn1_reg[k+1] = n1_r;
            sn2_reg[k+1] = n2_r;
        end
    end

    // ---- stage 7: radicand (1 - sinT2) << 28
    logic v7_reg;
    logic tir_7_reg;
    logic [56:0] rad_7_reg;
    logic signed [29:0] ci_7_reg;
    logic [15:0] n1_7_reg, n2_7_reg;
    logic [28:0] sin2;
    always_comb
    begin
        if (sdz_reg[SDN])
            sin2 = 29'd0;
        else if (squo_reg[SDN] > 29'(fdr_pkg::Q28_ONE))
            sin2 = 29'(fdr_pkg::Q28_ONE);
        else
            sin2 = squo_reg[SDN];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v7_reg <= 1'b0;
        else        v7_reg <= sv_reg[SDN];
    end
    always_ff @(posedge clk)
    begin
        tir_7_reg <= stir_reg[SDN];
        rad_7_reg <= {(29'(fdr_pkg::Q28_ONE) - sin2), 28'd0};
        ci_7_reg <= sci_reg[SDN];
        n1_7_reg <= sn1_reg[SDN];
        n2_7_reg <= sn2_reg[SDN];
    end

    // ---- floor square root of a 57-bit radicand: 29 result bits, two per stage, one in the last
    localparam int unsigned RTN = 15;
    logic        qv_reg   [RTN+1];
    logic [57:0] qrem_reg [RTN+1];
    logic [28:0] qroot_reg[RTN+1];
    logic [57:0] qrad_reg [RTN+1];
    logic        qtir_reg [RTN+1];
    logic signed [29:0] qci_reg [RTN+1];
    logic [15:0] qn1_reg [RTN+1];
    logic [15:0] qn2_reg [RTN+1];

    always_comb
    begin
        qv_reg[0] = v7_reg;
        qrem_reg[0] = 58'd0;
        qroot_reg[0] = 29'd0;
        qrad_reg[0] = {1'b0, rad_7_reg};
        qtir_reg[0] = tir_7_reg;
        qci_reg[0] = ci_7_reg;
        qn1_reg[0] = n1_7_reg;
        qn2_reg[0] = n2_7_reg;
    end

    // digit-by-digit: bring down two radicand bits, try (4*root+1)
    for (genvar k = 0; k < RTN; k++)
    begin : g_sqrt
        localparam int unsigned HA = 57 - 4 * k;
        logic [57:0] r_a, r_b, t_a, t_b;
        logic [28:0] o_a, o_b;
        always_comb
        begin
            r_a = (qrem_reg[k] << 2) | 58'((qrad_reg[k] >> (HA - 1)) & 58'd3);
            t_a = {27'd0, qroot_reg[k], 2'b01};
            o_a = qroot_reg[k] << 1;
            if (r_a >= t_a)
            begin
                r_a = r_a - t_a;
                o_a[0] = 1'b1;
            end
            if (k < RTN - 1)
            begin
                r_b = (r_a << 2) | 58'((qrad_reg[k] >> ((HA >= 3) ? HA - 3 : 0)) & 58'd3);
                t_b = {27'd0, o_a, 2'b01};
                o_b = o_a << 1;
                if (r_b >= t_b)
                begin
                    r_b = r_b - t_b;
                    o_b[0] = 1'b1;
                end
            end
            else
            begin
                r_b = r_a;
                t_b = t_a;
                o_b = o_a;
            end
        end
        logic v_r, tir_r;
        logic [57:0] rem_r, rad_r;
        logic [28:0] root_r;
        logic signed [29:0] ci_r;
        logic [15:0] n1_r, n2_r;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_r <= 1'b0;
            else        v_r <= qv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            rem_r <= r_b;
            root_r <= o_b;
            rad_r <= qrad_reg[k];
            tir_r <= qtir_reg[k];
            ci_r <= qci_reg[k];
            n1_r <= qn1_reg[k];
            n2_r <= qn2_reg[k];
        end
        always_comb
        begin
            qv_reg[k+1] = v_r;
            qrem_reg[k+1] = rem_r;
            qroot_reg[k+1] = root_r;
            qrad_reg[k+1] = rad_r;
            qtir_reg[k+1] = tir_r;
            qci_reg[k+1] = ci_r;
            qn1_reg[k+1] = n1_r;
            qn2_reg[k+1] = n2_r;
        end
    end

    // ---- stage 8: index times cosine products
    logic v8_reg, tir_8_reg;
    logic signed [47:0] n1c_8_reg, n2c_8_reg, n1t_8_reg, n2t_8_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v8_reg <= 1'b0;
        else        v8_reg <= qv_reg[RTN];
    end
    always_ff @(posedge clk)
    begin
        tir_8_reg <= qtir_reg[RTN];
        n1c_8_reg <= $signed({1'b0, qn1_reg[RTN]}) * qci_reg[RTN];
        n2c_8_reg <= $signed({1'b0, qn2_reg[RTN]}) * qci_reg[RTN];
        n1t_8_reg <= $signed({1'b0, qn1_reg[RTN]}) * $signed({1'b0, qroot_reg[RTN]});
        n2t_8_reg <= $signed({1'b0, qn2_reg[RTN]}) * $signed({1'b0, qroot_reg[RTN]});
    end

    // ---- stage 9: numerator and denominator magnitudes
    logic v9_reg, tir_9_reg;
    logic [47:0] no_9_reg, dn_9_reg, np_9_reg, dp_9_reg;
    logic signed [47:0] so, sd, sp, sq;
    always_comb
    begin
        so = n1c_8_reg - n2t_8_reg;
        sd = n1c_8_reg + n2t_8_reg;
        sp = n2c_8_reg - n1t_8_reg;
        sq = n2c_8_reg + n1t_8_reg;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v9_reg <= 1'b0;
        else        v9_reg <= v8_reg;
    end
    always_ff @(posedge clk)
    begin
        tir_9_reg <= tir_8_reg;
        no_9_reg <= so[47] ? 48'(-so) : 48'(so);
        dn_9_reg <= sd[47] ? 48'(-sd) : 48'(sd);
        np_9_reg <= sp[47] ? 48'(-sp) : 48'(sp);
        dp_9_reg <= sq[47] ? 48'(-sq) : 48'(sq);
    end

    // ---- stage 10: saturation checks
    logic v10_reg, tir_10_reg, sat_10_reg;
    logic [47:0] no_10_reg, dn_10_reg, np_10_reg, dp_10_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v10_reg <= 1'b0;
        else        v10_reg <= v9_reg;
    end
    always_ff @(posedge clk)
    begin
        tir_10_reg <= tir_9_reg;
        sat_10_reg <= (dn_9_reg == 48'd0) || (dp_9_reg == 48'd0)
                      || ({1'b0, no_9_reg} >= {dn_9_reg, 1'b0})
                      || ({1'b0, np_9_reg} >= {dp_9_reg, 1'b0});
        no_10_reg <= no_9_reg;
        dn_10_reg <= dn_9_reg;
        np_10_reg <= np_9_reg;
        dp_10_reg <= dp_9_reg;
    end

    // ---- two coefficient dividers: integer bit then 30 fraction bits
    logic        dv_reg  [DVN];
    logic        dpv_reg [DVN];
    logic [63:0] dro_reg [DVN];
    logic [63:0] dqo_reg [DVN];
    logic [63:0] drp_reg [DVN];
    logic [63:0] dqp_reg [DVN];
    logic [63:0] ddo_reg [DVN];
    logic [63:0] ddp_reg [DVN];
    logic        dflag_reg [DVN];
    logic        dtir_reg  [DVN];
    logic [63:0] dn64, dp64;

    assign dn64 = 64'(dn_10_reg);
    assign dp64 = 64'(dp_10_reg);

    // first stage: integer quotient bit (num < 2*den) then one fraction bit
    logic [63:0] ro0, rp0, qo0, qp0;
    always_comb
    begin
        ro0 = 64'(no_10_reg);
        qo0 = 64'd0;
        if (ro0 >= dn64)
        begin
            ro0 = ro0 - dn64;
            qo0 = 64'd1;
        end
        rp0 = 64'(np_10_reg);
        qp0 = 64'd0;
        if (rp0 >= dp64)
        begin
            rp0 = rp0 - dp64;
            qp0 = 64'd1;
        end
        ro0 = ro0 << 1;
        qo0 = qo0 << 1;
        if (ro0 >= dn64)
        begin
            ro0 = ro0 - dn64;
            qo0[0] = 1'b1;
        end
        rp0 = rp0 << 1;
        qp0 = qp0 << 1;
        if (rp0 >= dp64)
        begin
            rp0 = rp0 - dp64;
            qp0[0] = 1'b1;
        end
    end
    // each divider chain carries its own valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
            dpv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= v10_reg;
            dpv_reg[0] <= v10_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        dro_reg[0] <= ro0;
        dqo_reg[0] <= qo0;
        drp_reg[0] <= rp0;
        dqp_reg[0] <= qp0;
        ddo_reg[0] <= dn64;
        ddp_reg[0] <= dp64;
        dflag_reg[0] <= sat_10_reg;
        dtir_reg[0] <= tir_10_reg;
    end

    // remaining 29 fraction bits: 15 stages of two bits, last one only one bit used
    for (genvar k = 0; k < DVN - 1; k++)
    begin : g_cdiv
        fdr_div_stage u_orth (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_reg[k]),
            .in_rem    (dro_reg[k]),
            .in_den    (ddo_reg[k]),
            .in_quo    (dqo_reg[k]),
            .out_valid (dv_reg[k+1]),
            .out_rem   (dro_reg[k+1]),
            .out_quo   (dqo_reg[k+1])
        );
        fdr_div_stage u_par (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dpv_reg[k]),
            .in_rem    (drp_reg[k]),
            .in_den    (ddp_reg[k]),
            .in_quo    (dqp_reg[k]),
            .out_valid (dpv_reg[k+1]),
            .out_rem   (drp_reg[k+1]),
            .out_quo   (dqp_reg[k+1])
        );
        always_ff @(posedge clk)
        begin
            ddo_reg[k+1] <= ddo_reg[k];
            ddp_reg[k+1] <= ddp_reg[k];
            dflag_reg[k+1] <= dflag_reg[k];
            dtir_reg[k+1] <= dtir_reg[k];
        end
    end

    // 2 + 2*15 = 32 bits computed; the wanted Q30 quotient (31 bits) drops the last
    logic [30:0] ro_q, rp_q;
    assign ro_q = dqo_reg[DVN-1][31:1];
    assign rp_q = dqp_reg[DVN-1][31:1];

    // ---- stage 11: squares
    logic v11_reg, tir_11_reg, sat_11_reg;
    logic [61:0] sqo_11_reg, sqp_11_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v11_reg <= 1'b0;
        else        v11_reg <= dv_reg[DVN-1] && dpv_reg[DVN-1];
    end
    always_ff @(posedge clk)
    begin
        tir_11_reg <= dtir_reg[DVN-1];
        sat_11_reg <= dflag_reg[DVN-1];
        sqo_11_reg <= ro_q * ro_q;
        sqp_11_reg <= rp_q * rp_q;
    end

    // ---- stage 12: mean, rounding, saturation, output register
    logic [62:0] sum;
    logic [18:0] rnd;
    always_comb
    begin
        sum = 63'(sqo_11_reg) + 63'(sqp_11_reg);
        rnd = 19'(((sum >> 1) + (63'd1 << 44)) >> 45);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= v11_reg;
    end
    always_ff @(posedge clk)
    begin
        total_internal <= tir_11_reg;
        if (tir_11_reg || sat_11_reg || rnd > 19'(fdr_pkg::OUT_ONE))
            reflect_fraction <= fdr_pkg::OUT_ONE;
        else
            reflect_fraction <= rnd[15:0];
    end
endmodule
`default_nettype wire

// ===== rtl/fdr_checker.sv =====
// Port-level checker for the Fresnel reflectance unit, bound to the top level.
`default_nettype none
module fdr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [15:0] reflect_fraction,
    input wire logic        total_internal
);
    // result never exceeds 1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> reflect_fraction <= fdr_pkg::OUT_ONE)
        else $error("reflectance above one");

    // total internal reflection always reports exactly one
    a_tir: assert property (@(posedge clk) disable iff (!rst_n)
        (done && total_internal) |-> reflect_fraction == fdr_pkg::OUT_ONE)
        else $error("TIR without full reflectance");

    // pipeline never stalls the request side
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");
endmodule

bind fresnel_dielectric_reflectance_unit fdr_checker u_fdr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .busy             (busy),
    .done             (done),
    .reflect_fraction (reflect_fraction),
    .total_internal   (total_internal)
);
`default_nettype wire
